/* rtl/tes_pkg.sv */
package tes_pkg;

  localparam int NUM_SOURCES = 16;
  localparam int IDX_W       = $clog2(NUM_SOURCES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DUE_W       = 32;
  localparam int CD_W        = 16;
  localparam int CYC_W       = 20;

  localparam logic [DUE_W-1:0] DUE_LIMIT = 32'd999999;

  typedef enum logic [2:0] {
    OP_ARM_ABS   = 3'd0,
    OP_ARM_REL   = 3'd1,
    OP_ACK       = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_Q_PENDING = 3'd4,
    OP_Q_PASSED  = 3'd5,
    OP_Q_FRAME   = 3'd6,
    OP_ELAPSE    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ACT_RD,
    ST_H_RD,
    ST_SWEEP,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]       operation;
    logic [3:0]       handler;
    logic [CYC_W-1:0] cycles;
  } in_t;

  typedef struct packed {
    logic [3:0]              active_source;
    logic signed [CD_W-1:0]  countdown;
    logic                    expired;
    logic                    is_pending;
    logic signed [DUE_W-1:0] value;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [DUE_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } tbl_req_t;

endpackage

/* rtl/tes_table.sv */
module tes_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tes_pkg::tbl_req_t           req,
  output logic [tes_pkg::DUE_W-1:0]   rdata
);

  logic [tes_pkg::DUE_W-1:0]       mem [tes_pkg::NUM_SOURCES];
  logic [tes_pkg::NUM_SOURCES-1:0] written_r;
  logic [tes_pkg::DUE_W-1:0]       rdata_r;
  logic                            rd_written_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (req.we) begin
        written_r[req.waddr] <= 1'b1;
      end
      rd_written_r <= written_r[req.raddr];
    end
  end

  assign rdata = rd_written_r ? rdata_r : '0;

endmodule

/* rtl/timer_event_scheduler_core.sv */
// Timer event scheduler: a table of timed interrupt sources with a countdown
// to the earliest pending one.
// Input: drive in_data and raise start; the command transfers at the edge
// where start is high and busy is low. busy then stays high until the result
// has been shown. Result: out_valid is high for exactly one cycle with
// out_data; the receiver cannot stall it, so it must take it in that cycle.
// Steps per command after the start edge:
//   query pending, elapse, ignored commands      : execute only
//   query frame                                  : read active due time
//   query passed                                 : read active, then handler
//   arm                                          : write, then search
//   acknowledge, remove                          : read active, sweep table, then search
// busy drops in the cycle after the result, so the next command can transfer
// in the cycle after out_valid. The elapsed-time sweep of acknowledge and
// remove and the earliest-due search walk the single table memory one entry
// per cycle through its one read and one write port.
// Reset (synchronous, rst_n low) clears all pending flags, the countdown,
// the active source, overshoot and frame count; due times read as zero until
// armed. No clearing pass is needed.
module timer_event_scheduler_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  tes_pkg::in_t  in_data,
  output logic          out_valid,
  output tes_pkg::out_t out_data
);

  tes_pkg::state_t state_r, state_nxt;
  tes_pkg::op_t    op_r, op_nxt;
  logic [3:0]                        h_r, h_nxt;
  logic [tes_pkg::CYC_W-1:0]         cyc_r, cyc_nxt;
  logic [tes_pkg::NUM_SOURCES-1:0]   pend_r, pend_nxt;
  logic [tes_pkg::CD_W-1:0]          cd_r, cd_nxt;
  logic [tes_pkg::IDX_W-1:0]         act_r, act_nxt;
  logic [tes_pkg::DUE_W-1:0]         over_r, over_nxt;
  logic [tes_pkg::DUE_W-1:0]         frame_r, frame_nxt;
  logic [tes_pkg::DUE_W-1:0]         delta_r, delta_nxt;
  logic [tes_pkg::DUE_W-1:0]         value_r, value_nxt;
  logic [tes_pkg::DUE_W-1:0]         best_r, best_nxt;
  logic [tes_pkg::IDX_W-1:0]         bidx_r, bidx_nxt;
  logic [tes_pkg::DUE_W-1:0]         due0_r, due0_nxt;
  logic [tes_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                              scan_v_r, scan_v_nxt;
  logic [tes_pkg::IDX_W-1:0]         rd_idx_r;

  tes_pkg::tbl_req_t         tbl_req;
  logic [tes_pkg::DUE_W-1:0] rd_val;

  logic                      hok;
  logic [tes_pkg::IDX_W-1:0] h_idx;
  logic [tes_pkg::DUE_W-1:0] cd_ext;
  logic signed [21:0]        cd_dec;
  logic                      rd_last;
  logic                      better;
  logic [tes_pkg::IDX_W-1:0] fin_idx;
  logic [tes_pkg::DUE_W-1:0] fin_best;

  tes_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rdata (rd_val)
  );

  assign hok     = (32'(h_r) < tes_pkg::NUM_SOURCES);
  assign h_idx   = h_r[tes_pkg::IDX_W-1:0];
  assign cd_ext  = {{(tes_pkg::DUE_W-tes_pkg::CD_W){cd_r[tes_pkg::CD_W-1]}}, cd_r};
  assign cd_dec  = 22'(signed'(cd_r)) - signed'({2'b00, cyc_r});
  assign rd_last = (rd_idx_r == tes_pkg::IDX_W'(tes_pkg::NUM_SOURCES - 1));
  assign better  = pend_r[rd_idx_r] && ($signed(rd_val) < $signed(best_r));
  assign fin_idx  = better ? rd_idx_r : bidx_r;
  assign fin_best = better ? rd_val : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tes_pkg::ST_IDLE;
      op_r     <= tes_pkg::OP_Q_PENDING;
      h_r      <= '0;
      cyc_r    <= '0;
      pend_r   <= '0;
      cd_r     <= '0;
      act_r    <= '0;
      over_r   <= '0;
      frame_r  <= '0;
      delta_r  <= '0;
      value_r  <= '0;
      best_r   <= '0;
      bidx_r   <= '0;
      due0_r   <= '0;
      cnt_r    <= '0;
      scan_v_r <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      h_r      <= h_nxt;
      cyc_r    <= cyc_nxt;
      pend_r   <= pend_nxt;
      cd_r     <= cd_nxt;
      act_r    <= act_nxt;
      over_r   <= over_nxt;
      frame_r  <= frame_nxt;
      delta_r  <= delta_nxt;
      value_r  <= value_nxt;
      best_r   <= best_nxt;
      bidx_r   <= bidx_nxt;
      due0_r   <= due0_nxt;
      cnt_r    <= cnt_nxt;
      scan_v_r <= scan_v_nxt;
      rd_idx_r <= tbl_req.raddr;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    h_nxt      = h_r;
    cyc_nxt    = cyc_r;
    pend_nxt   = pend_r;
    cd_nxt     = cd_r;
    act_nxt    = act_r;
    over_nxt   = over_r;
    frame_nxt  = frame_r;
    delta_nxt  = delta_r;
    value_nxt  = value_r;
    best_nxt   = best_r;
    bidx_nxt   = bidx_r;
    due0_nxt   = due0_r;
    cnt_nxt    = cnt_r;
    scan_v_nxt = 1'b0;
    tbl_req.we    = 1'b0;
    tbl_req.waddr = h_idx;
    tbl_req.wdata = {{(tes_pkg::DUE_W-tes_pkg::CYC_W){1'b0}}, cyc_r};
    tbl_req.raddr = act_r;

    case (state_r)
      tes_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt    = tes_pkg::op_t'(in_data.operation);
          h_nxt     = in_data.handler;
          cyc_nxt   = in_data.cycles;
          state_nxt = tes_pkg::ST_EXEC;
        end
      end

      tes_pkg::ST_EXEC: begin
        value_nxt = '0;
        best_nxt  = tes_pkg::DUE_LIMIT;
        bidx_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = tes_pkg::ST_DONE;
        case (op_r)
          tes_pkg::OP_ARM_ABS, tes_pkg::OP_ARM_REL: begin
            if (hok) begin
              tbl_req.we = 1'b1;
              if (op_r == tes_pkg::OP_ARM_ABS) begin
                tbl_req.wdata = {{(tes_pkg::DUE_W-tes_pkg::CYC_W){1'b0}}, cyc_r} + over_r;
              end
              pend_nxt[h_idx] = 1'b1;
              state_nxt       = tes_pkg::ST_SCAN;
            end
          end
          tes_pkg::OP_ACK: begin
            over_nxt  = cd_ext;
            state_nxt = tes_pkg::ST_ACT_RD;
          end
          tes_pkg::OP_REMOVE: begin
            if (hok) begin
              pend_nxt[h_idx] = 1'b0;
              over_nxt        = cd_ext;
              state_nxt       = tes_pkg::ST_ACT_RD;
            end
          end
          tes_pkg::OP_Q_PASSED: begin
            if (hok) begin
              state_nxt = tes_pkg::ST_ACT_RD;
            end
          end
          tes_pkg::OP_Q_FRAME: begin
            state_nxt = tes_pkg::ST_ACT_RD;
          end
          tes_pkg::OP_ELAPSE: begin
            // saturate at the most negative countdown
            if (cd_dec < -22'sd32768) begin
              cd_nxt = 16'h8000;
            end else begin
              cd_nxt = cd_dec[tes_pkg::CD_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end

      // rd_val holds the due time of the active source
      tes_pkg::ST_ACT_RD: begin
        case (op_r)
          tes_pkg::OP_ACK, tes_pkg::OP_REMOVE: begin
            delta_nxt     = rd_val - over_r;
            tbl_req.raddr = '0;
            cnt_nxt       = tes_pkg::CNT_W'(1);
            state_nxt     = tes_pkg::ST_SWEEP;
          end
          tes_pkg::OP_Q_FRAME: begin
            value_nxt = frame_r + (rd_val - cd_ext);
            state_nxt = tes_pkg::ST_DONE;
          end
          default: begin
            delta_nxt     = rd_val - cd_ext;
            tbl_req.raddr = h_idx;
            state_nxt     = tes_pkg::ST_H_RD;
          end
        endcase
      end

      tes_pkg::ST_H_RD: begin
        value_nxt = rd_val - delta_r;
        state_nxt = tes_pkg::ST_DONE;
      end

      // take the elapsed time off every pending due time
      tes_pkg::ST_SWEEP: begin
        tbl_req.we    = pend_r[rd_idx_r];
        tbl_req.waddr = rd_idx_r;
        tbl_req.wdata = rd_val - delta_r;
        tbl_req.raddr = cnt_r[tes_pkg::IDX_W-1:0];
        cnt_nxt       = cnt_r + 1'b1;
        if (rd_last) begin
          frame_nxt = frame_r + delta_r;
          if (op_r == tes_pkg::OP_ACK) begin
            pend_nxt[act_r] = 1'b0;
          end
          cnt_nxt   = '0;
          state_nxt = tes_pkg::ST_SCAN;
        end
      end

      // search the pending source with the smallest due time below the limit
      tes_pkg::ST_SCAN: begin
        tbl_req.raddr = cnt_r[tes_pkg::IDX_W-1:0];
        if (32'(cnt_r) < tes_pkg::NUM_SOURCES) begin
          cnt_nxt    = cnt_r + 1'b1;
          scan_v_nxt = 1'b1;
        end
        if (scan_v_r) begin
          best_nxt = fin_best;
          bidx_nxt = fin_idx;
          if (rd_idx_r == '0) begin
            due0_nxt = rd_val;
          end
          if (rd_last) begin
            act_nxt   = fin_idx;
            cd_nxt    = (fin_idx == '0) ? due0_r[tes_pkg::CD_W-1:0]
                                        : fin_best[tes_pkg::CD_W-1:0];
            state_nxt = tes_pkg::ST_DONE;
          end
        end
      end

      tes_pkg::ST_DONE: begin
        state_nxt = tes_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = tes_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != tes_pkg::ST_IDLE);
  assign out_valid = (state_r == tes_pkg::ST_DONE);

  always_comb begin
    out_data.active_source = 4'(act_r);
    out_data.countdown     = cd_r;
    out_data.expired       = (cd_r == '0) || cd_r[tes_pkg::CD_W-1];
    out_data.is_pending    = hok && pend_r[h_idx];
    out_data.value         = value_r;
  end

endmodule

/* rtl/tes_checker.sv */
module tes_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input tes_pkg::out_t out_data
);

  // a transfer makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // results come only while a command is in flight
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  // a result is followed by a free block and not by a second result
  a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("block still busy after result");

  a_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.expired ==
      ((out_data.countdown == 16'sd0) || out_data.countdown[15]))
    else $error("expired flag does not match countdown");

endmodule

bind timer_event_scheduler_core tes_checker u_tes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
